// ----- hw/rtl/sorted_sparse_vector_store_macros.svh -----
// Assertion macros used by the sorted sparse vector store RTL.
`ifndef SORTED_SPARSE_VECTOR_STORE_MACROS_SVH
`define SORTED_SPARSE_VECTOR_STORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSVS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ssvs_pkg.sv -----
// Package: constants, command codes and control types of the sparse vector store.
package ssvs_pkg;

    localparam int SSVS_CAPACITY   = 16;
    localparam int SSVS_INDEX_BITS = 16;
    localparam int SSVS_VALUE_BITS = 32;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic ins;
        logic rem;
        logic upd;
    } ctrl_t;

endpackage

// ----- hw/rtl/sorted_sparse_vector_store.sv -----
// Top level: sorted sparse vector store built from a chain of slot cells.
// Result is registered: it is valid in the cycle after the item is accepted.
// Throughput: 1 item per cycle while m_ready takes results; all cells compare the key at once and shift in one step.
// A new item is taken while the previous result waits, as long as m_ready frees the register.
// Reset: synchronous active-low aresetn empties the table (entry count 0) and drops any result.
module sorted_sparse_vector_store
    import ssvs_pkg::*;
#(
    parameter int CAPACITY   = SSVS_CAPACITY,
    parameter int INDEX_BITS = SSVS_INDEX_BITS,
    parameter int VALUE_BITS = SSVS_VALUE_BITS,
    localparam int CNT_BITS  = $clog2(CAPACITY + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [INDEX_BITS-1:0] s_elem_index,
    input  logic [VALUE_BITS-1:0] s_write_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_read_value,
    output logic                  m_table_full,
    output logic [CNT_BITS-1:0]   m_entry_count
);

`include "sorted_sparse_vector_store_macros.svh"

    localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic                  out_full_reg, out_full_next;
    logic [CNT_BITS-1:0]   out_count_reg, out_count_next;

    logic [INDEX_BITS-1:0] idx_w  [CAPACITY];
    logic [VALUE_BITS-1:0] val_w  [CAPACITY];
    logic [CAPACITY-1:0]   less_w;
    logic [CAPACITY-1:0]   hit_w;
    logic [CAPACITY-1:0]   occ_w;
    logic [CAPACITY-1:0]   sorted_ok;

    logic                  accept;
    logic                  is_write;
    logic                  nonzero;
    logic                  any_hit;
    logic                  is_full;
    logic                  drop;
    logic [VALUE_BITS-1:0] hit_val;
    ctrl_t                 ctrl;

    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_write = (cmd_t'(s_cmd) == CMD_WRITE);
    assign nonzero  = |s_write_value;
    assign any_hit  = |hit_w;
    assign is_full  = (count_reg == CAP_CNT);
    assign drop     = is_write && nonzero && !any_hit && is_full;

    assign ctrl.upd = accept && is_write && nonzero && any_hit;
    assign ctrl.ins = accept && is_write && nonzero && !any_hit && !is_full;
    assign ctrl.rem = accept && is_write && !nonzero && any_hit;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic                  left_less;
            logic [INDEX_BITS-1:0] left_idx;
            logic [VALUE_BITS-1:0] left_val;
            logic [INDEX_BITS-1:0] right_idx;
            logic [VALUE_BITS-1:0] right_val;

            assign occ_w[k] = (CNT_BITS'(k) < count_reg);

            if (k == 0) begin : g_first
                assign left_less = 1'b1;
                assign left_idx  = s_elem_index;
                assign left_val  = s_write_value;
            end else begin : g_mid
                assign left_less = less_w[k-1];
                assign left_idx  = idx_w[k-1];
                assign left_val  = val_w[k-1];
            end

            if (k == CAPACITY - 1) begin : g_last
                assign right_idx    = '0;
                assign right_val    = '0;
                assign sorted_ok[k] = 1'b1;
            end else begin : g_inner
                assign right_idx    = idx_w[k+1];
                assign right_val    = val_w[k+1];
                assign sorted_ok[k] = !occ_w[k+1] || (idx_w[k] < idx_w[k+1]);
            end

            ssvs_cell #(
                .INDEX_BITS(INDEX_BITS),
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .key       (s_elem_index),
                .new_val   (s_write_value),
                .occ       (occ_w[k]),
                .left_less (left_less),
                .left_idx  (left_idx),
                .left_val  (left_val),
                .right_idx (right_idx),
                .right_val (right_val),
                .idx       (idx_w[k]),
                .val       (val_w[k]),
                .less      (less_w[k]),
                .hit       (hit_w[k])
            );
        end
    endgenerate

    always_comb begin
        hit_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_val = hit_val | (hit_w[i] ? val_w[i] : '0);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (ctrl.rem) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_full_next  = out_full_reg;
        out_count_next = out_count_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            out_valid_next = 1'b1;
            out_value_next = is_write ? '0 : hit_val;
            out_full_next  = drop;
            out_count_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        out_value_reg <= out_value_next;
        out_full_reg  <= out_full_next;
        out_count_reg <= out_count_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_read_value  = out_value_reg;
    assign m_table_full  = out_full_reg;
    assign m_entry_count = out_count_reg;

    `SSVS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CAP_CNT, "count over capacity")
    `SSVS_ASSERT_NOW(a_single_hit, aclk, aresetn, 1'b1, $onehot0(hit_w), "key held in two slots")
    `SSVS_ASSERT_NOW(a_sorted, aclk, aresetn, 1'b1, &sorted_ok, "slots out of order")
    `SSVS_ASSERT_NOW(a_full_flag, aclk, aresetn, out_valid_reg && out_full_reg, out_count_reg == CAP_CNT, "drop flagged below capacity")
    `SSVS_ASSERT_NEXT(a_insert_grows, aclk, aresetn, ctrl.ins, count_reg == $past(count_reg) + 1'b1, "insert did not grow count")

endmodule

// ----- hw/rtl/ssvs_cell.sv -----
// One slot of the sorted chain: holds an (index, value) pair and shifts with its neighbors.
module ssvs_cell
    import ssvs_pkg::*;
#(
    parameter int INDEX_BITS = SSVS_INDEX_BITS,
    parameter int VALUE_BITS = SSVS_VALUE_BITS
) (
    input  logic                  aclk,
    input  ctrl_t                 ctrl,
    input  logic [INDEX_BITS-1:0] key,
    input  logic [VALUE_BITS-1:0] new_val,
    input  logic                  occ,
    input  logic                  left_less,
    input  logic [INDEX_BITS-1:0] left_idx,
    input  logic [VALUE_BITS-1:0] left_val,
    input  logic [INDEX_BITS-1:0] right_idx,
    input  logic [VALUE_BITS-1:0] right_val,
    output logic [INDEX_BITS-1:0] idx,
    output logic [VALUE_BITS-1:0] val,
    output logic                  less,
    output logic                  hit
);

    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    assign less = occ && (idx_reg < key);
    assign hit  = occ && (idx_reg == key);
    assign idx  = idx_reg;
    assign val  = val_reg;

    always_comb begin
        idx_next = idx_reg;
        val_next = val_reg;
        if (ctrl.upd && hit) begin
            val_next = new_val;
        end
        if (ctrl.ins && !less) begin
            if (left_less) begin
                idx_next = key;
                val_next = new_val;
            end else begin
                idx_next = left_idx;
                val_next = left_val;
            end
        end
        if (ctrl.rem && !less) begin
            idx_next = right_idx;
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

endmodule
